FILE: rtl/ppt_pkg.sv
// shared types and constants of the planar point transform
package ppt_pkg;

    // field widths
    localparam int COORD_W           = 32;
    localparam int COEF_W            = 18;
    localparam int COEF_FRAC         = 16;
    localparam int R2_W              = 62;
    localparam int KIND_W            = 3;
    localparam int CFG_IDX_W         = 3;
    localparam int CFG_DATA_W        = 62;
    localparam int DEFAULT_FRAC_BITS = 16;

    // squared length width and quotient bits of the offset divider
    localparam int LEN_W = 66;
    localparam int QB    = 41;

    // largest offset magnitude, 2^40
    localparam logic [QB-1:0] OFFSET_LIMIT = QB'(1) << (QB - 1);

    // transform kinds
    localparam logic [KIND_W-1:0] K_LINE  = 3'd0;
    localparam logic [KIND_W-1:0] K_POINT = 3'd1;
    localparam logic [KIND_W-1:0] K_INV   = 3'd2;
    localparam logic [KIND_W-1:0] K_TRANS = 3'd3;
    localparam logic [KIND_W-1:0] K_ROT   = 3'd4;
    localparam logic [KIND_W-1:0] K_DIL   = 3'd5;
    localparam logic [KIND_W-1:0] K_IDENT = 3'd6;

    // register indexes
    localparam logic [CFG_IDX_W-1:0] REG_KIND = 3'd0;
    localparam logic [CFG_IDX_W-1:0] REG_AX   = 3'd1;
    localparam logic [CFG_IDX_W-1:0] REG_AY   = 3'd2;
    localparam logic [CFG_IDX_W-1:0] REG_BX   = 3'd3;
    localparam logic [CFG_IDX_W-1:0] REG_BY   = 3'd4;
    localparam logic [CFG_IDX_W-1:0] REG_CM   = 3'd5;
    localparam logic [CFG_IDX_W-1:0] REG_CS   = 3'd6;
    localparam logic [CFG_IDX_W-1:0] REG_R2   = 3'd7;

    typedef struct packed {
        logic signed [COORD_W-1:0] src_x;
        logic signed [COORD_W-1:0] src_y;
    } in_item_t;

    typedef struct packed {
        logic signed [COORD_W-1:0] out_x;
        logic signed [COORD_W-1:0] out_y;
        logic                      moved;
        logic                      saturated;
    } out_item_t;

    // divider result: quotient and overflow of the quotient range
    typedef struct packed {
        logic          ovf;
        logic [QB-1:0] q;
    } div_res_t;

endpackage

FILE: rtl/planar_point_transform.sv
// planar point transform top level: config registers, arithmetic pipeline, output register
// Maps each (src_x, src_y) vertex to its image under the configured transform. A vertex
// may enter every cycle unless the pipeline is stalled. A transaction passes 49 register
// stages, the first loaded at the edge that accepts it and the last being the output register.
// The stages are the five arithmetic stages, the 43-stage offset divider used for
// line reflection and circle inversion, and the output register. Every vertex goes through
// the full pipeline whatever the kind, so results leave in order. When a result is held by
// the output side the whole pipeline stalls and in_ready drops in the same cycle. Registers
// are written through cfg_we/cfg_index/cfg_data and must only change while the pipeline is
// empty.
module planar_point_transform #(
    parameter int FRAC_BITS = ppt_pkg::DEFAULT_FRAC_BITS
) (
    input  logic                             clk,
    input  logic                             rst_n,
    input  logic                             cfg_we,
    input  logic [ppt_pkg::CFG_IDX_W-1:0]    cfg_index,
    input  logic [ppt_pkg::CFG_DATA_W-1:0]   cfg_data,
    input  logic                             in_valid,
    output logic                             in_ready,
    input  ppt_pkg::in_item_t                in_item,
    output logic                             out_valid,
    input  logic                             out_ready,
    output ppt_pkg::out_item_t               out_item
);
    import ppt_pkg::*;

    localparam int NX_W    = (95 + FRAC_BITS > 99) ? 95 + FRAC_BITS : 99;
    localparam int DIV_LAT = QB + 2;
    localparam int PIPE_N  = 5 + DIV_LAT + 1;
    localparam int B_W     = 43;
    localparam logic [LEN_W-1:0] TINY_THR =
        LEN_W'(((64'd1 << (2 * FRAC_BITS)) - 64'd1) / 64'd1000000000000);
    localparam logic signed [B_W-1:0] MAX_C = B_W'(64'sd2147483647);
    localparam logic signed [B_W-1:0] MIN_C = B_W'(-64'sd2147483648);

    typedef struct packed {
        logic signed [B_W-1:0] base_x;
        logic signed [B_W-1:0] base_y;
        logic                  sgn_x;
        logic                  sgn_y;
        logic                  use_div;
        logic                  moved;
    } side_t;

    // configuration registers
    logic [KIND_W-1:0]        kind_reg;
    logic signed [31:0]       ax_reg, ay_reg, bx_reg, by_reg;
    logic signed [COEF_W-1:0] cm_reg, cs_reg;
    logic [R2_W-1:0]          r2_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            kind_reg <= K_IDENT;
            ax_reg   <= '0;
            ay_reg   <= '0;
            bx_reg   <= '0;
            by_reg   <= '0;
            cm_reg   <= 18'sd65536;
            cs_reg   <= '0;
            r2_reg   <= '0;
        end
        else if (cfg_we)
        begin
            unique case (cfg_index)
                REG_KIND: kind_reg <= cfg_data[KIND_W-1:0];
                REG_AX:   ax_reg   <= $signed(cfg_data[31:0]);
                REG_AY:   ay_reg   <= $signed(cfg_data[31:0]);
                REG_BX:   bx_reg   <= $signed(cfg_data[31:0]);
                REG_BY:   by_reg   <= $signed(cfg_data[31:0]);
                REG_CM:   cm_reg   <= $signed(cfg_data[COEF_W-1:0]);
                REG_CS:   cs_reg   <= $signed(cfg_data[COEF_W-1:0]);
                REG_R2:   r2_reg   <= cfg_data[R2_W-1:0];
            endcase
        end
    end

    // line direction, derived from static config
    logic signed [32:0] abx_reg, aby_reg;

    always_ff @(posedge clk)
    begin
        abx_reg <= 33'(bx_reg) - 33'(ax_reg);
        aby_reg <= 33'(by_reg) - 33'(ay_reg);
    end

    logic k_line, k_inv;
    assign k_line = kind_reg == K_LINE;
    assign k_inv  = kind_reg == K_INV;

    // pipeline control: global advance, valid bits travel with the data
    logic              en;
    logic [PIPE_N-1:0] vld_reg;

    assign en        = !vld_reg[PIPE_N-1] || out_ready;
    assign in_ready  = en;
    assign out_valid = vld_reg[PIPE_N-1];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            vld_reg <= '0;
        else if (en)
            vld_reg <= {vld_reg[PIPE_N-2:0], in_valid};
    end

    // stage 1: offsets from a
    logic signed [31:0] px1_reg, py1_reg;
    logic signed [32:0] dx1_reg, dy1_reg;
    logic signed [32:0] dx1_next, dy1_next;

    assign dx1_next = 33'(in_item.src_x) - 33'(ax_reg);
    assign dy1_next = 33'(in_item.src_y) - 33'(ay_reg);

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            px1_reg <= in_item.src_x;
            py1_reg <= in_item.src_y;
            dx1_reg <= dx1_next;
            dy1_reg <= dy1_next;
        end
    end

    // stage 2: products
    logic signed [32:0] mxa, mya;
    logic [32:0]        dxm1, dym1;
    logic signed [65:0] sqx_next, sqy_next, m1_next, m2_next;
    logic [63:0]        prxl_next, prxh_next, pryl_next, pryh_next;
    logic signed [50:0] dxcm_next, dycs_next, dxcs_next, dycm_next;

    assign mxa  = k_line ? abx_reg : dx1_reg;
    assign mya  = k_line ? aby_reg : dy1_reg;
    assign dxm1 = dx1_reg[32] ? $unsigned(-dx1_reg) : $unsigned(dx1_reg);
    assign dym1 = dy1_reg[32] ? $unsigned(-dy1_reg) : $unsigned(dy1_reg);

    assign sqx_next  = 66'(mxa) * 66'(mxa);
    assign sqy_next  = 66'(mya) * 66'(mya);
    assign m1_next   = 66'(dx1_reg) * 66'(abx_reg);
    assign m2_next   = 66'(dy1_reg) * 66'(aby_reg);
    assign prxl_next = 64'(dxm1) * 64'(r2_reg[30:0]);
    assign prxh_next = 64'(dxm1) * 64'(r2_reg[61:31]);
    assign pryl_next = 64'(dym1) * 64'(r2_reg[30:0]);
    assign pryh_next = 64'(dym1) * 64'(r2_reg[61:31]);
    assign dxcm_next = 51'(dx1_reg) * 51'(cm_reg);
    assign dycs_next = 51'(dy1_reg) * 51'(cs_reg);
    assign dxcs_next = 51'(dx1_reg) * 51'(cs_reg);
    assign dycm_next = 51'(dy1_reg) * 51'(cm_reg);

    logic signed [31:0] px2_reg, py2_reg;
    logic               dxn2_reg, dyn2_reg;
    logic signed [65:0] sqx_reg, sqy_reg, m1_reg, m2_reg;
    logic [63:0]        prxl_reg, prxh_reg, pryl_reg, pryh_reg;
    logic signed [50:0] dxcm_reg, dycs_reg, dxcs_reg, dycm_reg;

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            px2_reg  <= px1_reg;
            py2_reg  <= py1_reg;
            dxn2_reg <= dx1_reg[32];
            dyn2_reg <= dy1_reg[32];
            sqx_reg  <= sqx_next;
            sqy_reg  <= sqy_next;
            m1_reg   <= m1_next;
            m2_reg   <= m2_next;
            prxl_reg <= prxl_next;
            prxh_reg <= prxh_next;
            pryl_reg <= pryl_next;
            pryh_reg <= pryh_next;
            dxcm_reg <= dxcm_next;
            dycs_reg <= dycs_next;
            dxcs_reg <= dxcs_next;
            dycm_reg <= dycm_next;
        end
    end

    // stage 3: sums, degenerate checks, signs
    logic [LEN_W-1:0]   len3_next;
    logic signed [66:0] dot, dot_neg;
    logic [65:0]        dotm3_next;
    logic [94:0]        dxr2x_next, dxr2y_next;
    logic signed [51:0] vx3_next, vy3_next;
    logic               tiny3;
    logic               use3_next, moved3_next, sgnx3_next, sgny3_next;

    assign len3_next  = LEN_W'(sqx_reg[64:0]) + LEN_W'(sqy_reg[64:0]);
    assign dot        = 67'(m1_reg) + 67'(m2_reg);
    assign dot_neg    = -dot;
    assign dotm3_next = dot[66] ? $unsigned(dot_neg[65:0]) : $unsigned(dot[65:0]);
    assign dxr2x_next = 95'(prxl_reg) + (95'(prxh_reg) << 31);
    assign dxr2y_next = 95'(pryl_reg) + (95'(pryh_reg) << 31);
    assign vx3_next   = (kind_reg == K_ROT) ? 52'(dxcm_reg) - 52'(dycs_reg) : 52'(dxcm_reg);
    assign vy3_next   = (kind_reg == K_ROT) ? 52'(dxcs_reg) + 52'(dycm_reg) : 52'(dycm_reg);
    assign tiny3      = len3_next <= TINY_THR;
    assign use3_next  = (k_line || k_inv) && !tiny3;
    assign moved3_next = !(k_inv && tiny3);
    assign sgnx3_next = k_line ? (dot[66] ^ abx_reg[32]) : dxn2_reg;
    assign sgny3_next = k_line ? (dot[66] ^ aby_reg[32]) : dyn2_reg;

    logic signed [31:0] px3_reg, py3_reg;
    logic [LEN_W-1:0]   len3_reg;
    logic [65:0]        dotm3_reg;
    logic [94:0]        dxr2x3_reg, dxr2y3_reg;
    logic signed [51:0] vx3_reg, vy3_reg;
    logic               use3_reg, moved3_reg, sgnx3_reg, sgny3_reg;

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            px3_reg    <= px2_reg;
            py3_reg    <= py2_reg;
            len3_reg   <= len3_next;
            dotm3_reg  <= dotm3_next;
            dxr2x3_reg <= dxr2x_next;
            dxr2y3_reg <= dxr2y_next;
            vx3_reg    <= vx3_next;
            vy3_reg    <= vy3_next;
            use3_reg   <= use3_next;
            moved3_reg <= moved3_next;
            sgnx3_reg  <= sgnx3_next;
            sgny3_reg  <= sgny3_next;
        end
    end

    // stage 4: base points, rounding of rotate and dilate, numerator partial products
    logic [51:0]           vxm, vym;
    logic [35:0]           urx, ury;
    logic signed [B_W-1:0] rndx, rndy, refl_x, refl_y;
    logic signed [B_W-1:0] bx4_next, by4_next;
    logic [33:0]           tax, tay;
    logic [32:0]           abxm, abym;
    logic [66:0]           plx_next, phx_next, ply_next, phy_next;

    assign vxm    = vx3_reg[51] ? $unsigned(-vx3_reg) : $unsigned(vx3_reg);
    assign vym    = vy3_reg[51] ? $unsigned(-vy3_reg) : $unsigned(vy3_reg);
    assign urx    = 36'((vxm + (52'(1) << (COEF_FRAC - 1))) >> COEF_FRAC);
    assign ury    = 36'((vym + (52'(1) << (COEF_FRAC - 1))) >> COEF_FRAC);
    assign rndx   = vx3_reg[51] ? -$signed(B_W'(urx)) : $signed(B_W'(urx));
    assign rndy   = vy3_reg[51] ? -$signed(B_W'(ury)) : $signed(B_W'(ury));
    assign refl_x = (B_W'(ax_reg) <<< 1) - B_W'(px3_reg);
    assign refl_y = (B_W'(ay_reg) <<< 1) - B_W'(py3_reg);

    always_comb
    begin
        unique case (kind_reg)
            K_LINE:
            begin
                bx4_next = use3_reg ? refl_x : B_W'(px3_reg);
                by4_next = use3_reg ? refl_y : B_W'(py3_reg);
            end
            K_POINT:
            begin
                bx4_next = refl_x;
                by4_next = refl_y;
            end
            K_INV:
            begin
                bx4_next = use3_reg ? B_W'(ax_reg) : B_W'(px3_reg);
                by4_next = use3_reg ? B_W'(ay_reg) : B_W'(py3_reg);
            end
            K_TRANS:
            begin
                bx4_next = B_W'(px3_reg) + B_W'(abx_reg);
                by4_next = B_W'(py3_reg) + B_W'(aby_reg);
            end
            K_ROT, K_DIL:
            begin
                bx4_next = B_W'(ax_reg) + rndx;
                by4_next = B_W'(ay_reg) + rndy;
            end
            default:
            begin
                bx4_next = B_W'(px3_reg);
                by4_next = B_W'(py3_reg);
            end
        endcase
    end

    assign abxm     = abx_reg[32] ? $unsigned(-abx_reg) : $unsigned(abx_reg);
    assign abym     = aby_reg[32] ? $unsigned(-aby_reg) : $unsigned(aby_reg);
    assign tax      = {abxm, 1'b0};
    assign tay      = {abym, 1'b0};
    assign plx_next = 67'(dotm3_reg[32:0]) * 67'(tax);
    assign phx_next = 67'(dotm3_reg[65:33]) * 67'(tax);
    assign ply_next = 67'(dotm3_reg[32:0]) * 67'(tay);
    assign phy_next = 67'(dotm3_reg[65:33]) * 67'(tay);

    side_t            side4_reg;
    logic [LEN_W-1:0] len4_reg;
    logic [94:0]      dxr2x4_reg, dxr2y4_reg;
    logic [66:0]      plx_reg, phx_reg, ply_reg, phy_reg;

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            side4_reg.base_x  <= bx4_next;
            side4_reg.base_y  <= by4_next;
            side4_reg.sgn_x   <= sgnx3_reg;
            side4_reg.sgn_y   <= sgny3_reg;
            side4_reg.use_div <= use3_reg;
            side4_reg.moved   <= moved3_reg;
            len4_reg          <= len3_reg;
            dxr2x4_reg        <= dxr2x3_reg;
            dxr2y4_reg        <= dxr2y3_reg;
            plx_reg           <= plx_next;
            phx_reg           <= phx_next;
            ply_reg           <= ply_next;
            phy_reg           <= phy_next;
        end
    end

    // stage 5: numerators
    logic [NX_W-1:0]  nx5_next, ny5_next;
    logic [NX_W-1:0]  nx5_reg, ny5_reg;
    logic [LEN_W-1:0] len5_reg;
    side_t            side5_reg;

    assign nx5_next = k_inv ? (NX_W'(dxr2x4_reg) << FRAC_BITS)
                            : NX_W'(plx_reg) + (NX_W'(phx_reg) << 33);
    assign ny5_next = k_inv ? (NX_W'(dxr2y4_reg) << FRAC_BITS)
                            : NX_W'(ply_reg) + (NX_W'(phy_reg) << 33);

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            nx5_reg   <= nx5_next;
            ny5_reg   <= ny5_next;
            len5_reg  <= len4_reg;
            side5_reg <= side4_reg;
        end
    end

    // offset dividers, one per axis
    div_res_t res_x, res_y;

    ppt_div #(.NX_W(NX_W)) u_div_x (
        .clk (clk),
        .en  (en),
        .nx  (nx5_reg),
        .len (len5_reg),
        .res (res_x)
    );

    ppt_div #(.NX_W(NX_W)) u_div_y (
        .clk (clk),
        .en  (en),
        .nx  (ny5_reg),
        .len (len5_reg),
        .res (res_y)
    );

    // sideband delay matching the dividers
    side_t side_dl_reg [0:DIV_LAT-1];

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            side_dl_reg[0] <= side5_reg;
            for (int i = 1; i < DIV_LAT; i++)
            begin
                side_dl_reg[i] <= side_dl_reg[i-1];
            end
        end
    end

    // output stage: offset clamp, sign, add, saturation
    side_t                 sd;
    logic [QB-1:0]         ux, uy;
    logic signed [B_W-1:0] offx, offy, rx, ry;
    logic signed [31:0]    ox, oy;
    logic                  satx, saty;
    out_item_t             out_next, out_reg;

    assign sd   = side_dl_reg[DIV_LAT-1];
    assign ux   = (res_x.ovf || res_x.q > OFFSET_LIMIT) ? OFFSET_LIMIT : res_x.q;
    assign uy   = (res_y.ovf || res_y.q > OFFSET_LIMIT) ? OFFSET_LIMIT : res_y.q;
    assign offx = !sd.use_div ? '0 :
                  (sd.sgn_x ? -$signed(B_W'(ux)) : $signed(B_W'(ux)));
    assign offy = !sd.use_div ? '0 :
                  (sd.sgn_y ? -$signed(B_W'(uy)) : $signed(B_W'(uy)));
    assign rx   = sd.base_x + offx;
    assign ry   = sd.base_y + offy;

    always_comb
    begin
        satx = 1'b0;
        saty = 1'b0;
        priority if (rx > MAX_C)
        begin
            ox   = MAX_C[31:0];
            satx = 1'b1;
        end
        else if (rx < MIN_C)
        begin
            ox   = MIN_C[31:0];
            satx = 1'b1;
        end
        else
        begin
            ox   = rx[31:0];
        end
        priority if (ry > MAX_C)
        begin
            oy   = MAX_C[31:0];
            saty = 1'b1;
        end
        else if (ry < MIN_C)
        begin
            oy   = MIN_C[31:0];
            saty = 1'b1;
        end
        else
        begin
            oy   = ry[31:0];
        end
        out_next.out_x     = ox;
        out_next.out_y     = oy;
        out_next.moved     = sd.moved;
        out_next.saturated = satx || saty;
    end

    always_ff @(posedge clk)
    begin
        if (en)
            out_reg <= out_next;
    end

    assign out_item = out_reg;

    // checks
    a_unmoved_not_sat: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_item.moved |-> !out_item.saturated)
        else $error("unmoved vertex reported as saturated");

    a_unmoved_only_inv: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_item.moved |-> kind_reg == K_INV)
        else $error("unmoved vertex outside circle inversion");

    a_sat_at_limit: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_item.saturated |->
            (out_item.out_x == 32'sh7fffffff || out_item.out_x == 32'sh80000000 ||
             out_item.out_y == 32'sh7fffffff || out_item.out_y == 32'sh80000000))
        else $error("saturated flag without a clamped coordinate");

endmodule

FILE: rtl/ppt_div.sv
// pipelined restoring divider giving round(nx / len) with overflow flag
module ppt_div #(
    parameter int NX_W = 111
) (
    input  logic                      clk,
    input  logic                      en,
    input  logic [NX_W-1:0]           nx,
    input  logic [ppt_pkg::LEN_W-1:0] len,
    output ppt_pkg::div_res_t         res
);
    import ppt_pkg::*;

    localparam int N_W   = NX_W + 2;
    localparam int D_W   = LEN_W + 1;
    localparam int DIV_W = (N_W > D_W + QB) ? N_W : D_W + QB;

    logic [DIV_W-1:0] n_reg;
    logic [D_W-1:0]   d_reg;
    logic [DIV_W-1:0] n_next;
    logic [D_W-1:0]   d_next;

    logic [DIV_W-1:0] rem_reg [0:QB];
    logic [D_W-1:0]   dp_reg  [0:QB];
    logic [QB-1:0]    q_reg   [0:QB];
    logic             ovf_reg [0:QB];
    logic             ovf_next;

    // numerator 2n+d and denominator 2d, so that the quotient rounds half away
    assign n_next = DIV_W'({nx, 1'b0}) + DIV_W'(len);
    assign d_next = {len, 1'b0};

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            n_reg <= n_next;
            d_reg <= d_next;
        end
    end

    // quotient range check against 2^QB
    assign ovf_next = n_reg >= (DIV_W'(d_reg) << QB);

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            rem_reg[0] <= n_reg;
            dp_reg[0]  <= d_reg;
            q_reg[0]   <= '0;
            ovf_reg[0] <= ovf_next;
        end
    end

    // one quotient bit per stage, most significant first
    for (genvar k = 0; k < QB; k++)
    begin : g_step
        localparam int SH = QB - 1 - k;
        logic [DIV_W-1:0] dsh;
        logic             ge;
        logic [DIV_W-1:0] rem_next;

        assign dsh      = DIV_W'(dp_reg[k]) << SH;
        assign ge       = rem_reg[k] >= dsh;
        assign rem_next = ge ? (rem_reg[k] - dsh) : rem_reg[k];

        always_ff @(posedge clk)
        begin
            if (en)
            begin
                rem_reg[k+1] <= rem_next;
                dp_reg[k+1]  <= dp_reg[k];
                q_reg[k+1]   <= {q_reg[k][QB-2:0], ge};
                ovf_reg[k+1] <= ovf_reg[k];
            end
        end
    end

    assign res.ovf = ovf_reg[QB];
    assign res.q   = q_reg[QB];

endmodule

FILE: sim/planar_point_transform_test.sv
// testbench of the planar point transform: random stimulus, bit-exact prediction, in-order checks
module planar_point_transform_test;
    timeunit 1ns;
    timeprecision 1ps;

    import ppt_pkg::*;

    typedef logic signed [255:0] big_t;

    localparam int WATCHDOG_LIMIT = 4000;
    localparam int DRAIN_CYCLES   = 60;

    logic                  clk;
    logic                  rst_n;
    logic                  cfg_we;
    logic [CFG_IDX_W-1:0]  cfg_index;
    logic [CFG_DATA_W-1:0] cfg_data;
    logic                  in_valid;
    logic                  in_ready;
    in_item_t              in_item;
    logic                  out_valid;
    logic                  out_ready;
    out_item_t             out_item;

    // mirrored register contents
    logic [KIND_W-1:0]        kind_q;
    logic signed [COORD_W-1:0] ax_q, ay_q, bx_q, by_q;
    logic signed [COEF_W-1:0]  cos_q, sin_q;
    logic [R2_W-1:0]           rsq_q;

    in_item_t  vertex_queue[$];
    out_item_t pending_images[$];
    int        error_count;
    bit        quiet;
    int        src_gap;
    int        sink_gap;
    int        idle_cycles;

    planar_point_transform i_dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .in_valid  (in_valid),
        .in_ready  (in_ready),
        .in_item   (in_item),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .out_item  (out_item)
    );

    // clock
    initial
    begin
        clk = 1'b0;
    end

    always #4 clk = ~clk;

    // rounded quotient, ties away from zero, magnitude limited to 2^40
    function automatic big_t offset_div(big_t num, big_t den);
        big_t m;
        big_t q;
        m = (num < 0) ? -num : num;
        q = (2 * m + den) / (2 * den);
        if (q > (big_t'(1) <<< 40))
            q = big_t'(1) <<< 40;
        return (num < 0) ? -q : q;
    endfunction

    // coefficient product back to coordinate units, rounded half away from zero
    function automatic big_t coef_round(big_t v);
        big_t m;
        m = (v < 0) ? -v : v;
        m = (m + 32768) >> 16;
        return (v < 0) ? -m : m;
    endfunction

    function automatic logic signed [COORD_W-1:0] clamp_coord(big_t v, inout logic sat);
        if (v > 2147483647)
        begin
            sat = 1'b1;
            return 32'sh7fffffff;
        end
        if (v < -64'sd2147483648)
        begin
            sat = 1'b1;
            return 32'sh80000000;
        end
        return v[COORD_W-1:0];
    endfunction

    // image of one vertex under the current register settings
    function automatic out_item_t transform_point(in_item_t p);
        big_t px, py, ax, ay, dx, dy, abx, aby, len, dot, rx, ry, cm, cs, r2;
        logic moved;
        logic sat;
        out_item_t r;
        px = p.src_x;
        py = p.src_y;
        ax = ax_q;
        ay = ay_q;
        cm = cos_q;
        cs = sin_q;
        r2 = {194'b0, rsq_q};
        dx = px - ax;
        dy = py - ay;
        rx = px;
        ry = py;
        moved = 1'b1;
        sat = 1'b0;
        case (kind_q)
            K_LINE:
            begin
                abx = big_t'(bx_q) - ax;
                aby = big_t'(by_q) - ay;
                len = abx * abx + aby * aby;
                // a degenerate line passes the point through
                if (len != 0)
                begin
                    dot = dx * abx + dy * aby;
                    rx = 2 * ax - px + offset_div(dot * 2 * abx, len);
                    ry = 2 * ay - py + offset_div(dot * 2 * aby, len);
                end
            end
            K_POINT:
            begin
                rx = 2 * ax - px;
                ry = 2 * ay - py;
            end
            K_INV:
            begin
                len = dx * dx + dy * dy;
                if (len == 0)
                    moved = 1'b0;
                else
                begin
                    rx = ax + offset_div(dx * r2 * 65536, len);
                    ry = ay + offset_div(dy * r2 * 65536, len);
                end
            end
            K_TRANS:
            begin
                rx = px + (big_t'(bx_q) - ax);
                ry = py + (big_t'(by_q) - ay);
            end
            K_ROT:
            begin
                rx = ax + coef_round(dx * cm - dy * cs);
                ry = ay + coef_round(dx * cs + dy * cm);
            end
            K_DIL:
            begin
                rx = ax + coef_round(dx * cm);
                ry = ay + coef_round(dy * cm);
            end
            default:
            begin
            end
        endcase
        r.out_x = clamp_coord(rx, sat);
        r.out_y = clamp_coord(ry, sat);
        r.moved = moved;
        r.saturated = sat;
        return r;
    endfunction

    task automatic report_mismatch(string what, longint got, longint want);
        $display("mismatch %s: got %0d, expected %0d at %0t", what, got, want, $realtime);
        error_count++;
    endtask

    // vertex driver
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid <= 1'b0;
            in_item  <= '0;
            src_gap  <= 0;
        end
        else
        begin
            if (in_valid && in_ready)
                pending_images.insert(pending_images.size(), transform_point(in_item));
            if (!in_valid || in_ready)
            begin
                if (src_gap > 0)
                begin
                    src_gap  <= src_gap - 1;
                    in_valid <= 1'b0;
                end
                else if (vertex_queue.size() > 0)
                begin
                    in_item  <= vertex_queue.pop_front();
                    in_valid <= 1'b1;
                    if (!quiet && $urandom_range(7) == 0)
                        src_gap <= $urandom_range(10, 1);
                end
                else
                    in_valid <= 1'b0;
            end
        end
    end

    // result monitor with random back-pressure
    always @(posedge clk or negedge rst_n)
    begin
        out_item_t want;
        if (!rst_n)
        begin
            out_ready <= 1'b0;
            sink_gap  <= 0;
        end
        else
        begin
            if (out_valid && out_ready)
            begin
                if (pending_images.size() == 0)
                    report_mismatch("unexpected transaction", 1, 0);
                else
                begin
                    want = pending_images.pop_front();
                    if (out_item.out_x !== want.out_x)
                        report_mismatch("out_x", out_item.out_x, want.out_x);
                    if (out_item.out_y !== want.out_y)
                        report_mismatch("out_y", out_item.out_y, want.out_y);
                    if (out_item.moved !== want.moved)
                        report_mismatch("moved", out_item.moved, want.moved);
                    if (out_item.saturated !== want.saturated)
                        report_mismatch("saturated", out_item.saturated, want.saturated);
                end
            end
            if (sink_gap > 0)
            begin
                sink_gap  <= sink_gap - 1;
                out_ready <= 1'b0;
            end
            else if (!quiet && $urandom_range(9) == 0)
            begin
                sink_gap  <= $urandom_range(9, 0);
                out_ready <= 1'b0;
            end
            else
                out_ready <= 1'b1;
        end
    end

    // watchdog on cycles without any transaction
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            idle_cycles <= 0;
        else if ((in_valid && in_ready) || (out_valid && out_ready))
            idle_cycles <= 0;
        else if (idle_cycles >= WATCHDOG_LIMIT)
        begin
            $display("timeout: no transaction for %0d cycles", idle_cycles);
            $display("Verification failed");
            $finish;
        end
        else
            idle_cycles <= idle_cycles + 1;
    end

    task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] data);
        @(posedge clk);
        cfg_we    <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= data;
        case (idx)
            REG_KIND: kind_q = data[KIND_W-1:0];
            REG_AX:   ax_q = data[COORD_W-1:0];
            REG_AY:   ay_q = data[COORD_W-1:0];
            REG_BX:   bx_q = data[COORD_W-1:0];
            REG_BY:   by_q = data[COORD_W-1:0];
            REG_CM:   cos_q = data[COEF_W-1:0];
            REG_CS:   sin_q = data[COEF_W-1:0];
            default:  rsq_q = data[R2_W-1:0];
        endcase
    endtask

    task automatic configure(logic [KIND_W-1:0] k, logic [31:0] ax, logic [31:0] ay,
                             logic [31:0] bx, logic [31:0] by, logic [17:0] cm,
                             logic [17:0] cs, logic [R2_W-1:0] r2);
        write_reg(REG_KIND, CFG_DATA_W'(k));
        write_reg(REG_AX, {{30{ax[31]}}, ax});
        write_reg(REG_AY, {{30{ay[31]}}, ay});
        write_reg(REG_BX, {{30{bx[31]}}, bx});
        write_reg(REG_BY, {{30{by[31]}}, by});
        write_reg(REG_CM, {{44{cm[17]}}, cm});
        write_reg(REG_CS, {{44{cs[17]}}, cs});
        write_reg(REG_R2, r2);
        @(posedge clk);
        cfg_we <= 1'b0;
    endtask

    // wait for every result, then let the pipeline empty
    task automatic drain();
        while (vertex_queue.size() > 0 || in_valid || pending_images.size() > 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);
    endtask

    function automatic logic [31:0] rand_coord();
        case ($urandom_range(5))
            0: return $urandom;
            1: return 32'($signed($urandom_range(8388608)) - 4194304);
            2:
            begin
                case ($urandom_range(3))
                    0: return 32'h7fffffff;
                    1: return 32'h80000000;
                    2: return 32'h0;
                    default: return 32'hffffffff;
                endcase
            end
            default: return 32'($signed($urandom_range(67108864)) - 33554432);
        endcase
    endfunction

    function automatic logic [17:0] rand_coef();
        case ($urandom_range(4))
            0: return 18'd65536;
            1: return 18'h20000;
            2: return 18'h1ffff;
            default: return 18'($urandom);
        endcase
    endfunction

    function automatic logic [R2_W-1:0] rand_rsq();
        case ($urandom_range(4))
            0: return '0;
            1: return R2_W'({$urandom, $urandom});
            2: return {R2_W{1'b1}};
            default: return R2_W'($urandom_range(1048576)) << 16;
        endcase
    endfunction

    task automatic add_vertex(logic [31:0] x, logic [31:0] y);
        in_item_t v;
        v.src_x = x;
        v.src_y = y;
        vertex_queue.insert(vertex_queue.size(), v);
    endtask

    // stimulus
    initial
    begin
        logic [31:0] ax, ay, bx, by;
        int n;
        rst_n     = 1'b0;
        cfg_we    = 1'b0;
        cfg_index = '0;
        cfg_data  = '0;
        quiet     = 1'b0;
        error_count = 0;
        kind_q = K_IDENT;
        ax_q = '0;
        ay_q = '0;
        bx_q = '0;
        by_q = '0;
        cos_q = 18'sd65536;
        sin_q = '0;
        rsq_q = '0;
        repeat (2) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // reset settings: identity on field extremes
        add_vertex(32'h7fffffff, 32'h80000000);
        add_vertex(32'h80000000, 32'h7fffffff);
        add_vertex(32'h0, 32'hffffffff);
        drain();

        // directed: each kind with its special cases
        configure(K_LINE, 32'h10000, 32'h20000, 32'h10000, 32'h20000, 18'd65536, 18'd0, '0);
        add_vertex(32'h50000, 32'h7fffffff);
        drain();
        configure(K_LINE, 32'h80000000, 32'h80000000, 32'h7fffffff, 32'h7fffffff,
                  18'd0, 18'd0, '0);
        add_vertex(32'h7fffffff, 32'h80000000);
        add_vertex(32'h1234, 32'h0);
        drain();
        configure(K_POINT, 32'h7fffffff, 32'h80000000, 32'h0, 32'h0, 18'd0, 18'd0, '0);
        add_vertex(32'h80000000, 32'h7fffffff);
        add_vertex(32'h7fffffff, 32'h80000000);
        drain();
        configure(K_INV, 32'h30000, 32'hfffd0000, 32'h0, 32'h0, 18'd0, 18'd0,
                  62'h40000);
        add_vertex(32'h30000, 32'hfffd0000);
        add_vertex(32'h30001, 32'hfffd0000);
        add_vertex(32'h50000, 32'hfffd0000);
        drain();
        configure(K_INV, 32'h0, 32'h0, 32'h0, 32'h0, 18'd0, 18'd0, {R2_W{1'b1}});
        add_vertex(32'h1, 32'h0);
        add_vertex(32'h80000000, 32'h80000000);
        drain();
        configure(K_TRANS, 32'h80000000, 32'h0, 32'h7fffffff, 32'h10000, 18'd0, 18'd0, '0);
        add_vertex(32'h7fffffff, 32'h8000);
        drain();
        configure(K_ROT, 32'h10000, 32'h10000, 32'h0, 32'h0, 18'h20000, 18'h1ffff, '0);
        add_vertex(32'h7fffffff, 32'h80000000);
        add_vertex(32'h18000, 32'h8000);
        drain();
        configure(K_DIL, 32'h0, 32'h0, 32'h0, 32'h0, 18'h1ffff, 18'h20000, '0);
        add_vertex(32'h1, 32'hffffffff);
        add_vertex(32'h7fffffff, 32'h80000000);
        drain();
        configure(3'd7, 32'h5, 32'h6, 32'h7, 32'h8, 18'd3, 18'd4, 62'd5);
        add_vertex(32'h12345678, 32'h9abcdef0);
        drain();

        // random phases; the last few run without idling
        for (int ph = 0; ph < 40; ph++)
        begin
            quiet = (ph >= 35);
            ax = rand_coord();
            ay = rand_coord();
            bx = ($urandom_range(9) == 0) ? ax : rand_coord();
            by = ($urandom_range(9) == 0 && bx == ax) ? ay : rand_coord();
            configure(3'($urandom_range(7)), ax, ay, bx, by, rand_coef(), rand_coef(),
                      rand_rsq());
            n = $urandom_range(40, 20);
            for (int i = 0; i < n; i++)
            begin
                case ($urandom_range(9))
                    0: add_vertex(ax, ay);
                    1, 2: add_vertex(ax + 32'($urandom_range(8)) - 4,
                                     ay + 32'($urandom_range(8)) - 4);
                    default: add_vertex(rand_coord(), rand_coord());
                endcase
            end
            drain();
        end

        if (error_count == 0)
            $display("Verification passed");
        else
            $display("Verification failed");
        $finish;
    end

endmodule

FILE: sim.f
rtl/ppt_pkg.sv
rtl/ppt_div.sv
rtl/planar_point_transform.sv
sim/planar_point_transform_test.sv
